// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// prop must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, prop)

`endif

`endif

// File: sv/pcd_pkg.sv
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared constants and types of the CRC-16 packet deframer.
// ----------------------------------------------------------------------------
package pcd_pkg;

  localparam int unsigned MaxPayload = 64;
  localparam int unsigned LenW       = 7;
  localparam int unsigned IdxW       = 6;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 8;

  localparam logic [CfgIdxW-1:0] REG_HDR_HIGH = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_HDR_LOW  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DEV0     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DEV1     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DEV2     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_LEN0     = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_LEN1     = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_LEN2     = 3'd7;

  localparam logic [15:0] CrcPoly = 16'h1021;

  typedef enum logic [2:0] {
    KIND_DATA         = 3'd0,
    KIND_OK           = 3'd1,
    KIND_BAD_HEADER   = 3'd2,
    KIND_BAD_DEVICE   = 3'd3,
    KIND_CRC_MISMATCH = 3'd4
  } kind_e;

  typedef enum logic [5:0] {
    PH_IDLE     = 6'b000001,
    PH_HDR_LOW  = 6'b000010,
    PH_DEVICE   = 6'b000100,
    PH_PAYLOAD  = 6'b001000,
    PH_CRC_HIGH = 6'b010000,
    PH_CRC_LOW  = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       start_of_packet;
  } in_word_t;

  typedef struct packed {
    logic [2:0]      result_kind;
    logic [7:0]      data_value;
    logic [IdxW-1:0] data_index;
    logic [1:0]      device_index;
    logic [LenW-1:0] payload_length;
  } out_word_t;

endpackage

// File: sv/pcd_if.sv
// ----------------------------------------------------------------------------
// pcd_in_if / pcd_out_if
// Valid/ready channels for received bytes and deframer results.
// ----------------------------------------------------------------------------
interface pcd_in_if
  import pcd_pkg::*;
  ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       start_of_packet;

  modport source (output valid, output rx_byte, output start_of_packet, input ready);
  modport sink   (input valid, input rx_byte, input start_of_packet, output ready);
endinterface

interface pcd_out_if
  import pcd_pkg::*;
  ();
  logic            valid;
  logic            ready;
  logic [2:0]      result_kind;
  logic [7:0]      data_value;
  logic [IdxW-1:0] data_index;
  logic [1:0]      device_index;
  logic [LenW-1:0] payload_length;

  modport source (output valid, output result_kind, output data_value, output data_index,
                  output device_index, output payload_length, input ready);
  modport sink   (input valid, input result_kind, input data_value, input data_index,
                  input device_index, input payload_length, output ready);
endinterface

// File: sv/pcd_crc16_step.sv
// ----------------------------------------------------------------------------
// pcd_crc16_step
// One-byte update of CRC-16 CCITT (poly 0x1021, MSB first, no reflection).
// ----------------------------------------------------------------------------
module pcd_crc16_step
  import pcd_pkg::*;
(
  input  logic [15:0] crc_i,
  input  logic [7:0]  data_i,
  output logic [15:0] crc_o
);

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {data_i, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

// File: sv/packet_crc16_deframer_core.sv
// ----------------------------------------------------------------------------
// packet_crc16_deframer_core
// Header/device check, payload pass-through and CRC-16 XModem verdict.
// Pipeline: a byte enters the input register at the edge that accepts it, and its
//   result enters the result register at the edge on which that byte advances.
// Throughput: one byte per cycle while the result side is ready; the byte-wide CRC step sets the path.
// Reset: asynchronous, clears phase, counters, CRC and all config registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module packet_crc16_deframer_core
  import pcd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  pcd_in_if.sink              rx_i,
  pcd_out_if.source           res_o
);

  // config
  logic [7:0]      hdr_high_q, hdr_low_q;
  logic [7:0]      dev_code_q [3];
  logic [LenW-1:0] len_q      [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_high_q <= '0;
      hdr_low_q  <= '0;
      for (int k = 0; k < 3; k++) begin
        dev_code_q[k] <= '0;
        len_q[k]      <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HDR_HIGH: hdr_high_q    <= cfg_data_i;
        REG_HDR_LOW:  hdr_low_q     <= cfg_data_i;
        REG_DEV0:     dev_code_q[0] <= cfg_data_i;
        REG_DEV1:     dev_code_q[1] <= cfg_data_i;
        REG_DEV2:     dev_code_q[2] <= cfg_data_i;
        REG_LEN0:     len_q[0]      <= cfg_data_i[LenW-1:0];
        REG_LEN1:     len_q[1]      <= cfg_data_i[LenW-1:0];
        REG_LEN2:     len_q[2]      <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic     s1_valid_q;
  in_word_t s1_q;
  logic     adv;
  logic     out_valid_q;
  out_word_t out_q;

  assign adv        = s1_valid_q && (!out_valid_q || res_o.ready);
  assign rx_i.ready = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      s1_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      s1_q.rx_byte         <= rx_i.rx_byte;
      s1_q.start_of_packet <= rx_i.start_of_packet;
    end
  end

  // packet state
  phase_e          phase_q, phase_d;
  logic [15:0]     crc_q, crc_d, crc_in, crc_next;
  logic [LenW-1:0] count_q, count_d, exp_len_q, exp_len_d;
  logic [1:0]      dev_q, dev_d;
  logic [7:0]      crc_hi_q, crc_hi_d;

  assign crc_in = (phase_q == PH_DEVICE) ? 16'h0000 : crc_q;

  pcd_crc16_step u_crc (
    .crc_i  (crc_in),
    .data_i (s1_q.rx_byte),
    .crc_o  (crc_next)
  );

  // first matching device wins
  logic            dev_hit;
  logic [1:0]      dev_sel;
  logic [LenW-1:0] len_sel, len_clamp, count_inc;

  always_comb begin
    dev_hit = 1'b0;
    dev_sel = 2'd0;
    for (int k = 2; k >= 0; k--) begin
      if (s1_q.rx_byte == dev_code_q[k]) begin
        dev_hit = 1'b1;
        dev_sel = 2'(k);
      end
    end
  end

  assign len_sel   = len_q[dev_sel];
  assign len_clamp = (len_sel > LenW'(MaxPayload)) ? LenW'(MaxPayload) : len_sel;
  assign count_inc = count_q + LenW'(1);

  logic      emit;
  out_word_t res_d;

  always_comb begin
    phase_d   = phase_q;
    crc_d     = crc_q;
    count_d   = count_q;
    exp_len_d = exp_len_q;
    dev_d     = dev_q;
    crc_hi_d  = crc_hi_q;
    emit      = 1'b0;
    res_d     = '0;
    if (adv) begin
      if (s1_q.start_of_packet) begin
        if (s1_q.rx_byte != hdr_high_q) begin
          phase_d           = PH_IDLE;
          emit              = 1'b1;
          res_d.result_kind = KIND_BAD_HEADER;
        end else begin
          phase_d = PH_HDR_LOW;
        end
      end else begin
        case (phase_q)
          PH_HDR_LOW: begin
            if (s1_q.rx_byte != hdr_low_q) begin
              phase_d           = PH_IDLE;
              emit              = 1'b1;
              res_d.result_kind = KIND_BAD_HEADER;
            end else begin
              phase_d = PH_DEVICE;
            end
          end
          PH_DEVICE: begin
            if (!dev_hit) begin
              phase_d           = PH_IDLE;
              emit              = 1'b1;
              res_d.result_kind = KIND_BAD_DEVICE;
            end else begin
              dev_d     = dev_sel;
              exp_len_d = len_clamp;
              count_d   = '0;
              crc_d     = crc_next;
              phase_d   = (len_clamp == '0) ? PH_CRC_HIGH : PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            emit                 = 1'b1;
            res_d.result_kind    = KIND_DATA;
            res_d.data_value     = s1_q.rx_byte;
            res_d.data_index     = count_q[IdxW-1:0];
            res_d.device_index   = dev_q;
            res_d.payload_length = exp_len_q;
            crc_d                = crc_next;
            count_d              = count_inc;
            if (count_inc >= exp_len_q) begin
              phase_d = PH_CRC_HIGH;
            end
          end
          PH_CRC_HIGH: begin
            crc_hi_d = s1_q.rx_byte;
            phase_d  = PH_CRC_LOW;
          end
          PH_CRC_LOW: begin
            phase_d              = PH_IDLE;
            emit                 = 1'b1;
            res_d.result_kind    = ({crc_hi_q, s1_q.rx_byte} == crc_q) ? KIND_OK
                                                                       : KIND_CRC_MISMATCH;
            res_d.device_index   = dev_q;
            res_d.payload_length = exp_len_q;
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      crc_q     <= '0;
      count_q   <= '0;
      exp_len_q <= '0;
      dev_q     <= '0;
      crc_hi_q  <= '0;
    end else begin
      phase_q   <= phase_d;
      crc_q     <= crc_d;
      count_q   <= count_d;
      exp_len_q <= exp_len_d;
      dev_q     <= dev_d;
      crc_hi_q  <= crc_hi_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || res_o.ready) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res_d;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.result_kind    = out_q.result_kind;
  assign res_o.data_value     = out_q.data_value;
  assign res_o.data_index     = out_q.data_index;
  assign res_o.device_index   = out_q.device_index;
  assign res_o.payload_length = out_q.payload_length;

  // checks
  `ASSERT_ALWAYS(a_data_idx_in_range, clk_i, rst_ni,
    (out_valid_q && out_q.result_kind == KIND_DATA) |->
      (LenW'(out_q.data_index) < out_q.payload_length))
  `ASSERT_ALWAYS(a_count_bounded, clk_i, rst_ni,
    (phase_q == PH_PAYLOAD) |-> (count_q < exp_len_q))
  `ASSERT_ALWAYS(a_stage_held, clk_i, rst_ni,
    (s1_valid_q && !adv) |=> (s1_valid_q && $stable(s1_q)))
  `ASSERT_NEVER(a_emit_without_byte, clk_i, rst_ni, emit && !adv)

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the CRC-16 packet deframer against a cycle-free predictor of its
// packet rules: a table of directed bytes after reset, then phases of mostly
// well-formed random packets under several register settings. Both channels
// idle at random; every result word is compared field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  import pcd_pkg::*;

  typedef enum logic [1:0] {BYTE_LIT, BYTE_CRC_HI, BYTE_CRC_LO} byte_src_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_GIVEN} row_chk_e;

  typedef struct packed {
    byte_src_e  src;
    logic       sop;
    logic [7:0] rx_byte;
    row_chk_e   chk;
    out_word_t  res;
  } dir_row_t;

  localparam out_word_t OkEmpty   = '{KIND_OK, 8'd0, 6'd0, 2'd0, 7'd0};
  localparam out_word_t BadHeader = '{KIND_BAD_HEADER, 8'd0, 6'd0, 2'd0, 7'd0};
  localparam out_word_t BadDevice = '{KIND_BAD_DEVICE, 8'd0, 6'd0, 2'd0, 7'd0};
  localparam out_word_t CrcBadEmpty = '{KIND_CRC_MISMATCH, 8'd0, 6'd0, 2'd0, 7'd0};

  localparam int DirRows       = 26;
  localparam int DirSecondPart = 20;
  localparam int RandomBytes   = 850;
  localparam int RandomPhases  = 5;

  dir_row_t directed_rows [DirRows] = '{
    '{BYTE_LIT,    1'b0, 8'h00, CHK_NONE,  '0},
    '{BYTE_LIT,    1'b1, 8'h00, CHK_NONE,  '0},
    '{BYTE_LIT,    1'b0, 8'h00, CHK_NONE,  '0},
    '{BYTE_LIT,    1'b0, 8'h00, CHK_NONE,  '0},
    '{BYTE_LIT,    1'b0, 8'h00, CHK_NONE,  '0},
    '{BYTE_LIT,    1'b0, 8'h00, CHK_GIVEN, OkEmpty},
    '{BYTE_LIT,    1'b1, 8'hFF, CHK_GIVEN, BadHeader},
    '{BYTE_LIT,    1'b0, 8'h5A, CHK_NONE,  '0},
    '{BYTE_LIT,    1'b1, 8'h00, CHK_NONE,  '0},
    '{BYTE_LIT,    1'b0, 8'hFF, CHK_GIVEN, BadHeader},
    '{BYTE_LIT,    1'b1, 8'h00, CHK_NONE,  '0},
    '{BYTE_LIT,    1'b0, 8'h00, CHK_NONE,  '0},
    '{BYTE_LIT,    1'b0, 8'h80, CHK_GIVEN, BadDevice},
    '{BYTE_LIT,    1'b1, 8'h00, CHK_NONE,  '0},
    '{BYTE_LIT,    1'b0, 8'h00, CHK_NONE,  '0},
    '{BYTE_LIT,    1'b1, 8'h00, CHK_NONE,  '0},
    '{BYTE_LIT,    1'b0, 8'h00, CHK_NONE,  '0},
    '{BYTE_LIT,    1'b0, 8'h00, CHK_NONE,  '0},
    '{BYTE_LIT,    1'b0, 8'h12, CHK_NONE,  '0},
    '{BYTE_LIT,    1'b0, 8'h34, CHK_GIVEN, CrcBadEmpty},
    '{BYTE_LIT,    1'b1, 8'hFF, CHK_MODEL, '0},
    '{BYTE_LIT,    1'b0, 8'h80, CHK_MODEL, '0},
    '{BYTE_LIT,    1'b0, 8'h7F, CHK_MODEL, '0},
    '{BYTE_LIT,    1'b0, 8'hFF, CHK_MODEL, '0},
    '{BYTE_CRC_HI, 1'b0, 8'h00, CHK_MODEL, '0},
    '{BYTE_CRC_LO, 1'b0, 8'h00, CHK_MODEL, '0}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  pcd_in_if  rx_if ();
  pcd_out_if res_if ();

  packet_crc16_deframer_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rx_i       (rx_if),
    .res_o      (res_if)
  );

  // predictor state
  logic [7:0]      shadow_regs [8];
  phase_e          deframe_phase;
  logic [15:0]     crc_acc;
  logic [LenW-1:0] payload_cnt;
  logic [LenW-1:0] exp_len;
  logic [1:0]      dev_sel;
  logic [7:0]      crc_hi_rx;

  out_word_t pending_words [$];
  int        fail_count;
  int        bytes_sent;
  bit        src_fast;
  bit        sink_fast;

  function automatic logic [15:0] crc16_xmodem(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    int i;
    r = c ^ {d, 8'h00};
    for (i = 0; i < 8; i++) r = r[15] ? ((r << 1) ^ CrcPoly) : (r << 1);
    return r;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, input logic sop,
                                      output out_word_t r);
    bit hit;
    int k;
    int sel;
    logic [LenW-1:0] len;
    r = '0;
    if (sop) begin
      if (b != shadow_regs[REG_HDR_HIGH]) begin
        deframe_phase = PH_IDLE;
        r.result_kind = KIND_BAD_HEADER;
        return 1'b1;
      end
      deframe_phase = PH_HDR_LOW;
      return 1'b0;
    end
    case (deframe_phase)
      PH_HDR_LOW: begin
        if (b != shadow_regs[REG_HDR_LOW]) begin
          deframe_phase = PH_IDLE;
          r.result_kind = KIND_BAD_HEADER;
          return 1'b1;
        end
        deframe_phase = PH_DEVICE;
        return 1'b0;
      end
      PH_DEVICE: begin
        hit = 1'b0;
        sel = 0;
        for (k = 0; k < 3; k++) begin
          if (!hit && b == shadow_regs[REG_DEV0 + k]) begin
            hit = 1'b1;
            sel = k;
          end
        end
        if (!hit) begin
          deframe_phase = PH_IDLE;
          r.result_kind = KIND_BAD_DEVICE;
          return 1'b1;
        end
        len = shadow_regs[REG_LEN0 + sel][LenW-1:0];
        if (len > MaxPayload) len = LenW'(MaxPayload);
        dev_sel = 2'(sel);
        exp_len = len;
        payload_cnt = '0;
        crc_acc = crc16_xmodem(16'h0000, b);
        deframe_phase = (len == 0) ? PH_CRC_HIGH : PH_PAYLOAD;
        return 1'b0;
      end
      PH_PAYLOAD: begin
        r = '{KIND_DATA, b, payload_cnt[IdxW-1:0], dev_sel, exp_len};
        crc_acc = crc16_xmodem(crc_acc, b);
        payload_cnt = payload_cnt + 1'b1;
        if (payload_cnt >= exp_len) deframe_phase = PH_CRC_HIGH;
        return 1'b1;
      end
      PH_CRC_HIGH: begin
        crc_hi_rx = b;
        deframe_phase = PH_CRC_LOW;
        return 1'b0;
      end
      PH_CRC_LOW: begin
        deframe_phase = PH_IDLE;
        r.result_kind = ({crc_hi_rx, b} == crc_acc) ? KIND_OK : KIND_CRC_MISMATCH;
        r.device_index = dev_sel;
        r.payload_length = exp_len;
        return 1'b1;
      end
      default: begin
        deframe_phase = PH_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  // drive one word, wait for acceptance, then predict its result
  task automatic send_byte(input logic [7:0] b, input logic sop,
                           input row_chk_e chk = CHK_MODEL, input out_word_t given = '0);
    int gap;
    out_word_t r;
    bit has;
    if ($urandom_range(0, 19) == 0) src_fast = !src_fast;
    gap = src_fast ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_if.valid           <= 1'b1;
    rx_if.rx_byte         <= b;
    rx_if.start_of_packet <= sop;
    do @(posedge clk_i); while (!rx_if.ready);
    bytes_sent++;
    has = deframe_byte(b, sop, r);
    case (chk)
      CHK_MODEL: if (has) pending_words.push_back(r);
      CHK_GIVEN: pending_words.push_back(given);
      default: ;
    endcase
  endtask

  task automatic settle();
    rx_if.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_config(input logic [7:0] hdr_hi, input logic [7:0] hdr_lo,
                             input logic [7:0] dev0, input logic [7:0] dev1,
                             input logic [7:0] dev2, input logic [7:0] len0,
                             input logic [7:0] len1, input logic [7:0] len2);
    logic [7:0] vals [8];
    int i;
    vals = '{hdr_hi, hdr_lo, dev0, dev1, dev2, len0, len1, len2};
    for (i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= REG_HDR_HIGH + CfgIdxW'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      shadow_regs[i] = (i >= REG_LEN0) ? {1'b0, vals[i][6:0]} : vals[i];
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_packet();
    int unsigned sel, k, len, cut, i;
    logic [15:0] crc_tx;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      k = $urandom_range(0, 2);
      send_byte(shadow_regs[REG_HDR_HIGH], 1'b1);
      send_byte(shadow_regs[REG_HDR_LOW], 1'b0);
      send_byte(shadow_regs[REG_DEV0 + k], 1'b0);
      len = exp_len;
      // truncated packets get cut off by the next start
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len + 1) : len + 2;
      for (i = 0; i < len && i < cut; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
      crc_tx = crc_acc;
      if ($urandom_range(0, 7) == 0) crc_tx = crc_tx ^ (16'h1 << $urandom_range(0, 15));
      if (cut > len) send_byte(crc_tx[15:8], 1'b0);
      if (cut > len + 1) send_byte(crc_tx[7:0], 1'b0);
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end else if (sel < 80) begin
      if ($urandom_range(0, 1) == 0) begin
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        send_byte(shadow_regs[REG_HDR_HIGH], 1'b1);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end else if (sel < 90) begin
      send_byte(shadow_regs[REG_HDR_HIGH], 1'b1);
      send_byte(shadow_regs[REG_HDR_LOW], 1'b0);
      send_byte(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      repeat ($urandom_range(1, 4)) begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // result side: random stalls, in-order compare
  initial begin
    int stall;
    out_word_t e;
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 19) == 0) sink_fast = !sink_fast;
      stall = sink_fast ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (res_if.valid !== 1'b1);
      if (pending_words.size() == 0) begin
        $error("unexpected word: result_kind %0d", res_if.result_kind);
        fail_count++;
      end else begin
        e = pending_words.pop_front();
        if (res_if.result_kind !== e.result_kind) begin
          $error("result_kind: expected %0d, got %0d", e.result_kind, res_if.result_kind);
          fail_count++;
        end
        if (res_if.data_value !== e.data_value) begin
          $error("data_value: expected %0d, got %0d", e.data_value, res_if.data_value);
          fail_count++;
        end
        if (res_if.data_index !== e.data_index) begin
          $error("data_index: expected %0d, got %0d", e.data_index, res_if.data_index);
          fail_count++;
        end
        if (res_if.device_index !== e.device_index) begin
          $error("device_index: expected %0d, got %0d", e.device_index,
                 res_if.device_index);
          fail_count++;
        end
        if (res_if.payload_length !== e.payload_length) begin
          $error("payload_length: expected %0d, got %0d", e.payload_length,
                 res_if.payload_length);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int i, p, phase_end, drain;
    logic [7:0] b, d0, d1, d2;
    dir_row_t row;
    fail_count = 0;
    bytes_sent = 0;
    src_fast   = 1'b0;
    sink_fast  = 1'b0;
    for (i = 0; i < 8; i++) shadow_regs[i] = 8'h00;
    deframe_phase = PH_IDLE;
    crc_acc     = '0;
    payload_cnt = '0;
    exp_len     = '0;
    dev_sel     = '0;
    crc_hi_rx   = '0;
    rst_ni                <= 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_idx_i             <= REG_HDR_HIGH;
    cfg_data_i            <= '0;
    rx_if.valid           <= 1'b0;
    rx_if.rx_byte         <= '0;
    rx_if.start_of_packet <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DirRows; i++) begin
      if (i == DirSecondPart) begin
        settle();
        // duplicate codes: first one wins; long length clamps
        load_config(8'hFF, 8'h80, 8'h7F, 8'h7F, 8'hFF, 8'h01, 8'hFF, 8'h40);
      end
      row = directed_rows[i];
      case (row.src)
        BYTE_CRC_HI: b = crc_acc[15:8];
        BYTE_CRC_LO: b = crc_acc[7:0];
        default:     b = row.rx_byte;
      endcase
      send_byte(b, row.sop, row.chk, row.res);
    end

    for (p = 0; p < RandomPhases; p++) begin
      settle();
      d0 = 8'($urandom_range(0, 255));
      d1 = 8'($urandom_range(0, 255));
      d2 = ($urandom_range(0, 3) == 0) ? d0 : 8'($urandom_range(0, 255));
      case (p)
        0: load_config(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h00, 8'h7F, 8'h40);
        1: load_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       d0, d1, d2, 8'h01, 8'h3F, 8'h41);
        default: load_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             d0, d1, d2,
                             8'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                            : $urandom_range(0, 8)),
                             8'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                            : $urandom_range(0, 8)),
                             8'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                            : $urandom_range(0, 8)));
      endcase
      phase_end = bytes_sent + RandomBytes / RandomPhases;
      while (bytes_sent < phase_end) random_packet();
    end

    rx_if.valid <= 1'b0;
    drain = 0;
    while (pending_words.size() != 0 && drain < 2000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (8) @(posedge clk_i);
    if (pending_words.size() != 0) begin
      $error("%0d expected words never arrived", pending_words.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
